// ===== design/frame_crc16_append_check_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for frame_crc16_append_check_core
// Concurrent checks that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAME_CRC16_APPEND_CHECK_CORE_ASSERT_SVH
`define FRAME_CRC16_APPEND_CHECK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FCRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcrc assertion failed");
`define FCRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcrc assertion failed");
`else
`define FCRC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FCRC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/fcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrc_pkg
// Types, constants and CRC-16/MODBUS functions for the frame CRC core.
// ----------------------------------------------------------------------------
`default_nettype none

package fcrc_pkg;

   localparam int unsigned PAYLOAD_LEN_DEF = 22;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   typedef enum logic {
      MODE_GEN   = 1'b0,
      MODE_CHECK = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      APP_IDLE,
      APP_HIGH,
      APP_LOW
   } app_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last_of_frame;
      logic        crc_ok;
      logic [15:0] crc_value;
   } rsp_item_type;

   typedef struct packed {
      logic item_taken;
      logic append_busy;
   } status_type;

   // reflected table entry, eight shift steps
   function automatic logic [15:0] crc_table_entry(input logic [7:0] idx);
      logic [15:0] c;
      c = {8'h00, idx};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      return {8'h00, crc[15:8]} ^ crc_table_entry(crc[7:0] ^ b);
   endfunction

endpackage

`default_nettype wire

// ===== design/fcrc_if.sv =====
// ----------------------------------------------------------------------------
// fcrc channel interfaces
// Valid/ready channels for input items, result items and the mode register.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface fcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        last_of_frame;
   logic        crc_ok;
   logic [15:0] crc_value;
   modport source (output valid, output out_byte, output last_of_frame, output crc_ok,
                   output crc_value, input ready);
   modport sink   (input valid, input out_byte, input last_of_frame, input crc_ok,
                   input crc_value, output ready);
endinterface

interface fcrc_csr_if;
   logic valid;
   logic ready;
   logic frame_mode;
   modport source (output valid, output frame_mode, input ready);
   modport sink   (input valid, input frame_mode, output ready);
endinterface

`default_nettype wire

// ===== design/frame_crc16_append_check_core.sv =====
// ----------------------------------------------------------------------------
// frame_crc16_append_check_core
// Fixed-length frames with CRC-16/MODBUS append (generate) or check.
// ----------------------------------------------------------------------------
//  channel   dir   fields                                         handshake
//  req_ch    in    data_byte, frame_start                         valid/ready
//  rsp_ch    out   out_byte, last_of_frame, crc_ok, crc_value     valid/ready
//  csr_ch    in    frame_mode                                     valid/ready
//
//  One item per cycle while the result register is free and no CRC append is
//  running; an accepted item goes to the input register, then the result register.
//  Generate mode adds two CRC items per frame, holding the input while the append sequencer drives the result register.
//  Synchronous active-high reset; mode resets to generate, CRC to 0xFFFF.
//  A stalled result register stops the frame logic and, once the input
//  register is full, the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_crc16_append_check_core_assert.svh"

module frame_crc16_append_check_core
   import fcrc_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   fcrc_req_if.sink    req_ch,
   fcrc_rsp_if.source  rsp_ch,
   fcrc_csr_if.sink    csr_ch
);

   mode_type     mode_ff;
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         req_accept;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   status_type   status;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !in_valid_ff || status.item_taken;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_accept ? 1'b1 : (status.item_taken ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_GEN;
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_ch.valid) begin
            mode_ff <= mode_type'(csr_ch.frame_mode);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.data_byte   <= req_ch.data_byte;
         in_item_ff.frame_start <= req_ch.frame_start;
      end
   end

   fcrc_frame_ctrl #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_frame_ctrl (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (in_valid_ff),
      .in_item   (in_item_ff),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .status    (status)
   );

   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.out_byte      = rsp_item.out_byte;
   assign rsp_ch.last_of_frame = rsp_item.last_of_frame;
   assign rsp_ch.crc_ok        = rsp_item.crc_ok;
   assign rsp_ch.crc_value     = rsp_item.crc_value;

   `FCRC_ASSERT_IMP(a_ok_only_last, clock, reset, rsp_ch.valid && rsp_ch.crc_ok, rsp_ch.last_of_frame)
   `FCRC_ASSERT_IMP(a_ok_only_check, clock, reset, rsp_ch.valid && rsp_ch.crc_ok, mode_ff == MODE_CHECK)
   `FCRC_ASSERT_IMP(a_no_take_append, clock, reset, status.append_busy, !status.item_taken)
   `FCRC_ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !status.item_taken, in_valid_ff)

endmodule

`default_nettype wire

// ===== design/fcrc_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcrc_frame_ctrl
// Frame counter, CRC update, CRC append sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcrc_frame_ctrl
   import fcrc_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mode_type     mode,
   input  wire logic         in_valid,
   input  wire req_item_type in_item,
   input  wire logic         rsp_ready,
   output      logic         rsp_valid,
   output      rsp_item_type rsp_item,
   output      status_type   status
);

   localparam int unsigned CNT_W = $clog2(PAYLOAD_LEN + 2);
   localparam logic [CNT_W-1:0] LEN_C  = CNT_W'(PAYLOAD_LEN);
   localparam logic [CNT_W-1:0] LEN_P1 = CNT_W'(PAYLOAD_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       rx_high_ff, rx_high_in;
   logic [15:0]      app_crc_ff;
   app_state_type    app_state_ff, app_state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic             out_free;
   logic             item_taken;
   logic             emit;
   logic             start_append;
   logic [15:0]      crc_base;
   logic [CNT_W-1:0] cnt_base;
   logic [15:0]      crc_upd;
   rsp_item_type     res0;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign item_taken = in_valid && out_free && (app_state_ff == APP_IDLE);

   // per-item frame logic
   always_comb begin
      crc_base     = in_item.frame_start ? CRC_INIT : crc_ff;
      cnt_base     = in_item.frame_start ? '0 : count_ff;
      crc_upd      = CRC_INIT;
      crc_in       = crc_ff;
      count_in     = count_ff;
      rx_high_in   = rx_high_ff;
      start_append = 1'b0;
      res0.out_byte      = in_item.data_byte;
      res0.last_of_frame = 1'b0;
      res0.crc_ok        = 1'b0;
      res0.crc_value     = crc_base;
      if (mode == MODE_GEN) begin
         if (cnt_base >= LEN_C) begin
            crc_base = CRC_INIT;
            cnt_base = '0;
         end
         crc_upd        = crc_step(crc_base, in_item.data_byte);
         res0.crc_value = crc_upd;
         if ((cnt_base + CNT_ONE) == LEN_C) begin
            start_append = 1'b1;
            crc_in       = CRC_INIT;
            count_in     = '0;
         end else begin
            crc_in   = crc_upd;
            count_in = cnt_base + CNT_ONE;
         end
      end else begin
         if (cnt_base > LEN_P1) begin
            crc_base = CRC_INIT;
            cnt_base = '0;
         end
         if (cnt_base < LEN_C) begin
            crc_upd        = crc_step(crc_base, in_item.data_byte);
            res0.crc_value = crc_upd;
            crc_in         = crc_upd;
            count_in       = cnt_base + CNT_ONE;
         end else if (cnt_base == LEN_C) begin
            rx_high_in     = in_item.data_byte;
            crc_in         = crc_base;
            count_in       = cnt_base + CNT_ONE;
            res0.crc_value = crc_base;
         end else begin
            res0.last_of_frame = 1'b1;
            res0.crc_ok        = ({rx_high_ff, in_item.data_byte} == crc_base);
            res0.crc_value     = crc_base;
            crc_in             = CRC_INIT;
            count_in           = '0;
         end
      end
   end

   // append sequencer: next state
   always_comb begin
      app_state_in = app_state_ff;
      unique case (app_state_ff)
         APP_IDLE: begin
            if (item_taken && start_append) begin
               app_state_in = APP_HIGH;
            end
         end
         APP_HIGH: begin
            if (out_free) begin
               app_state_in = APP_LOW;
            end
         end
         APP_LOW: begin
            if (out_free) begin
               app_state_in = APP_IDLE;
            end
         end
         default: app_state_in = APP_IDLE;
      endcase
   end

   // append sequencer: outputs
   always_comb begin
      emit        = 1'b0;
      rsp_item_in = res0;
      unique case (app_state_ff)
         APP_IDLE: begin
            emit = item_taken;
         end
         APP_HIGH: begin
            emit                      = out_free;
            rsp_item_in.out_byte      = app_crc_ff[15:8];
            rsp_item_in.last_of_frame = 1'b0;
            rsp_item_in.crc_ok        = 1'b0;
            rsp_item_in.crc_value     = app_crc_ff;
         end
         APP_LOW: begin
            emit                      = out_free;
            rsp_item_in.out_byte      = app_crc_ff[7:0];
            rsp_item_in.last_of_frame = 1'b1;
            rsp_item_in.crc_ok        = 1'b0;
            rsp_item_in.crc_value     = app_crc_ff;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         count_ff     <= '0;
         rx_high_ff   <= '0;
         app_state_ff <= APP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         app_state_ff <= app_state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (item_taken) begin
            crc_ff     <= crc_in;
            count_ff   <= count_in;
            rx_high_ff <= rx_high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_taken && start_append) begin
         app_crc_ff <= crc_upd;
      end
      if (emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item           = rsp_item_ff;
   assign status.item_taken  = item_taken;
   assign status.append_busy = (app_state_ff != APP_IDLE);

endmodule

`default_nettype wire
